// ===== sv/wpm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_pkg
// Shared constants and types of the wildcard pattern matcher.
// ----------------------------------------------------------------------------
package wpm_pkg;

   localparam int MAX_POSITIONS = 32;
   localparam int CSR_DATA_W    = 64;
   localparam int CSR_ADDR_W    = 6;
   localparam int REG_IDX_W     = 3;
   localparam int LEN_W         = 6;

   localparam logic [7:0] CHAR_STAR = 8'h2A;
   localparam logic [7:0] CHAR_ANY  = 8'h3F;

   localparam logic CMD_BYTE = 1'b0;
   localparam logic CMD_END  = 1'b1;

   localparam logic [REG_IDX_W-1:0] REG_BYTES_LO     = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_BYTES_MID_LO = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_BYTES_MID_HI = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_BYTES_HI     = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_STAR_MASK    = 3'd4;
   localparam logic [REG_IDX_W-1:0] REG_ANY_MASK     = 3'd5;
   localparam logic [REG_IDX_W-1:0] REG_LENGTH       = 3'd6;

   typedef struct packed {
      logic [8*MAX_POSITIONS-1:0] pat_bytes;
      logic [MAX_POSITIONS-1:0]   star_mask;
      logic [MAX_POSITIONS-1:0]   any_mask;
      logic [LEN_W-1:0]           pattern_length;
   } pattern_cfg_type;

endpackage

// ===== sv/wpm_req_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_req_if
// Input channel: one byte or end-of-sequence command per item.
// ----------------------------------------------------------------------------
interface wpm_req_if;
   logic       valid;
   logic       ready;
   logic       command;
   logic [7:0] seq_byte;

   modport source (output valid, command, seq_byte, input ready);
   modport sink   (input valid, command, seq_byte, output ready);
endinterface

// ===== sv/wpm_rsp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_rsp_if
// Result channel: match verdict for each item.
// ----------------------------------------------------------------------------
interface wpm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic final_res;
   logic any_alive;

   modport source (output valid, matched, final_res, any_alive, input ready);
   modport sink   (input valid, matched, final_res, any_alive, output ready);
endinterface

// ===== sv/wpm_csr.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_csr
// APB register file holding the pattern; flags every write to a known register.
// ----------------------------------------------------------------------------
module wpm_csr
   import wpm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready,
   output pattern_cfg_type       cfg,
   output logic                  cfg_written
);

   logic [63:0]            bytes_lo_ff, bytes_mid_lo_ff, bytes_mid_hi_ff, bytes_hi_ff;
   logic [31:0]            star_ff, any_ff;
   logic [LEN_W-1:0]       len_ff;
   logic [REG_IDX_W-1:0]   idx;
   logic                   wr;

   assign pready = 1'b1;
   assign idx    = paddr[CSR_ADDR_W-1:3];
   assign wr     = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         bytes_lo_ff     <= '0;
         bytes_mid_lo_ff <= '0;
         bytes_mid_hi_ff <= '0;
         bytes_hi_ff     <= '0;
         star_ff         <= '0;
         any_ff          <= '0;
         len_ff          <= '0;
         cfg_written     <= 1'b0;
      end else begin
         cfg_written <= 1'b0;
         if (wr) begin
            unique case (idx)
               REG_BYTES_LO: begin
                  bytes_lo_ff <= pwdata;
                  cfg_written <= 1'b1;
               end
               REG_BYTES_MID_LO: begin
                  bytes_mid_lo_ff <= pwdata;
                  cfg_written     <= 1'b1;
               end
               REG_BYTES_MID_HI: begin
                  bytes_mid_hi_ff <= pwdata;
                  cfg_written     <= 1'b1;
               end
               REG_BYTES_HI: begin
                  bytes_hi_ff <= pwdata;
                  cfg_written <= 1'b1;
               end
               REG_STAR_MASK: begin
                  star_ff     <= pwdata[31:0];
                  cfg_written <= 1'b1;
               end
               REG_ANY_MASK: begin
                  any_ff      <= pwdata[31:0];
                  cfg_written <= 1'b1;
               end
               REG_LENGTH: begin
                  len_ff      <= pwdata[LEN_W-1:0];
                  cfg_written <= 1'b1;
               end
               default: begin
               end
            endcase
         end
      end
   end

   always_comb begin
      unique case (idx)
         REG_BYTES_LO:     prdata = bytes_lo_ff;
         REG_BYTES_MID_LO: prdata = bytes_mid_lo_ff;
         REG_BYTES_MID_HI: prdata = bytes_mid_hi_ff;
         REG_BYTES_HI:     prdata = bytes_hi_ff;
         REG_STAR_MASK:    prdata = {32'd0, star_ff};
         REG_ANY_MASK:     prdata = {32'd0, any_ff};
         REG_LENGTH:       prdata = {{(CSR_DATA_W-LEN_W){1'b0}}, len_ff};
         default:          prdata = '0;
      endcase
   end

   assign cfg.pat_bytes      = {bytes_hi_ff, bytes_mid_hi_ff, bytes_mid_lo_ff, bytes_lo_ff};
   assign cfg.star_mask      = star_ff;
   assign cfg.any_mask       = any_ff;
   assign cfg.pattern_length = len_ff;

endmodule

// ===== sv/wpm_nfa.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wpm_nfa
// Next-state logic of the position set: advance by one byte, close over stars; an end command rearms it.
// ----------------------------------------------------------------------------
module wpm_nfa
   import wpm_pkg::*;
#(
   parameter int PATTERN_LEN = MAX_POSITIONS
) (
   input  pattern_cfg_type        cfg,
   input  logic [PATTERN_LEN:0]   active,
   input  logic                   command,
   input  logic [7:0]             seq_byte,
   output logic [PATTERN_LEN:0]   next_active,
   output logic [PATTERN_LEN:0]   rearm_vec,
   output logic                   matched,
   output logic                   any_alive
);

   localparam int SW   = PATTERN_LEN + 1;
   localparam int IDXW = $clog2(SW);

   logic [IDXW-1:0]        eff_len;
   logic [PATTERN_LEN-1:0] star_e;
   logic [PATTERN_LEN-1:0] hit_e;
   logic [SW-1:0]          step_vec;
   logic [SW-1:0]          stepped;

   // star run closure as a parallel prefix: bit j gets bit k when all of
   // positions k..j-1 are stars
   function automatic logic [SW-1:0] close_stars(input logic [SW-1:0] s,
                                                 input logic [PATTERN_LEN-1:0] st);
      logic [SW-1:0] g, p, g_n, p_n;
      g = s;
      p = {st, 1'b0};
      for (int l = 0; l < IDXW; l++) begin
         g_n = g;
         p_n = p;
         for (int j = 0; j < SW; j++) begin
            if (j >= (1 << l)) begin
               g_n[j] = g[j] | (p[j] & g[j - (1 << l)]);
               p_n[j] = p[j] & p[j - (1 << l)];
            end
         end
         g = g_n;
         p = p_n;
      end
      return g;
   endfunction

   always_comb begin
      if (32'(cfg.pattern_length) > PATTERN_LEN) begin
         eff_len = IDXW'(PATTERN_LEN);
      end else begin
         eff_len = IDXW'(cfg.pattern_length);
      end
   end

   always_comb begin
      for (int i = 0; i < PATTERN_LEN; i++) begin
         logic [7:0] b;
         logic       in_use;
         b         = cfg.pat_bytes[i*8 +: 8];
         in_use    = (i < 32'(eff_len));
         star_e[i] = in_use && (cfg.star_mask[i] || b == CHAR_STAR);
         hit_e[i]  = in_use && (cfg.any_mask[i] || b == CHAR_ANY || b == seq_byte);
      end
   end

   always_comb begin
      step_vec = '0;
      for (int i = 0; i < PATTERN_LEN; i++) begin
         if (active[i] && star_e[i]) begin
            step_vec[i] = 1'b1;
         end
         if (active[i] && !star_e[i] && hit_e[i]) begin
            step_vec[i+1] = 1'b1;
         end
      end
   end

   assign rearm_vec = close_stars(SW'(1), star_e);
   assign stepped   = close_stars(step_vec, star_e);

   always_comb begin
      if (command == CMD_END) begin
         next_active = rearm_vec;
         matched     = active[eff_len];
         any_alive   = |active;
      end else begin
         next_active = stepped;
         matched     = stepped[eff_len];
         any_alive   = |stepped;
      end
   end

endmodule

// ===== sv/wildcard_pattern_matcher.sv =====
`timescale 1ns / 1ps
// Pipeline: the accepted item is registered in the input stage, then its result in the output stage.
// Throughput: one item per cycle unless the result channel stalls; the position-set
// update is one pass of byte compare plus a log-depth star closure between input and result regs.
// Reset: synchronous; clears all pattern registers and arms the empty pattern.
// A register write rearms the position set at the clock edge after the write.
// ----------------------------------------------------------------------------
// wildcard_pattern_matcher
// Streams bytes through a wildcard NFA ('*', '?', literals) of up to 32
// positions and reports the match state after each item.
// ----------------------------------------------------------------------------
module wildcard_pattern_matcher
   import wpm_pkg::*;
#(
   parameter int PATTERN_LEN = MAX_POSITIONS
) (
   input  logic                  clock,
   input  logic                  reset,
   wpm_req_if.sink               req_ch,
   wpm_rsp_if.source             rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   pattern_cfg_type      cfg;
   logic                 cfg_written;

   logic                 in_valid_ff;
   logic                 in_cmd_ff;
   logic [7:0]           in_byte_ff;
   logic [PATTERN_LEN:0] active_ff;

   logic                 out_valid_ff;
   logic                 out_matched_ff;
   logic                 out_final_ff;
   logic                 out_alive_ff;

   logic [PATTERN_LEN:0] active_in;
   logic [PATTERN_LEN:0] rearm_vec;
   logic                 matched_in;
   logic                 alive_in;
   logic                 advance;

   wpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .psel        (psel),
      .penable     (penable),
      .pwrite      (pwrite),
      .paddr       (paddr),
      .pwdata      (pwdata),
      .prdata      (prdata),
      .pready      (pready),
      .cfg         (cfg),
      .cfg_written (cfg_written)
   );

   wpm_nfa #(.PATTERN_LEN(PATTERN_LEN)) u_nfa (
      .cfg         (cfg),
      .active      (active_ff),
      .command     (in_cmd_ff),
      .seq_byte    (in_byte_ff),
      .next_active (active_in),
      .rearm_vec   (rearm_vec),
      .matched     (matched_in),
      .any_alive   (alive_in)
   );

   assign advance      = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         out_valid_ff  <= 1'b0;
         active_ff     <= (PATTERN_LEN+1)'(1);
      end else begin
         // cfg_written is high in the cycle after the write, new pattern in place
         if (cfg_written) begin
            active_ff <= rearm_vec;
         end else if (advance) begin
            active_ff <= active_in;
         end
         if (req_ch.ready) begin
            in_valid_ff <= req_ch.valid;
         end
         if (advance) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ch.valid && req_ch.ready) begin
         in_cmd_ff  <= req_ch.command;
         in_byte_ff <= req_ch.seq_byte;
      end
      if (advance) begin
         out_matched_ff <= matched_in;
         out_final_ff   <= (in_cmd_ff == CMD_END);
         out_alive_ff   <= alive_in;
      end
   end

   assign rsp_ch.valid     = out_valid_ff;
   assign rsp_ch.matched   = out_matched_ff;
   assign rsp_ch.final_res = out_final_ff;
   assign rsp_ch.any_alive = out_alive_ff;

`ifndef SYNTH
   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      (advance && in_cmd_ff == CMD_END && !cfg_written) |=> active_ff == $past(rearm_vec))
      else $error("end item did not rearm the position set");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> (in_valid_ff && $stable(in_byte_ff) && $stable(in_cmd_ff)))
      else $error("stalled input item was lost or changed");

   a_write_rearm: assert property (@(posedge clock) disable iff (reset)
      cfg_written |=> active_ff == $past(rearm_vec))
      else $error("register write did not rearm the position set");
`endif

endmodule
